// ===== rtl/lfu_pkg.sv =====
`default_nettype none
package lfu_pkg;
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int CNT_W   = 16;
	localparam int STAMP_W = 32;
	localparam int LIM_W   = 5;
	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
	localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};
	localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(16);
	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_PUT = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture the incoming word and clear the scan results
		logic scan;      // examine the entry at the scan pointer
		logic commit;    // apply the update and build the result
	} lfu_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_last;
	} lfu_sts_t;
endpackage
`default_nettype wire

// ===== rtl/lfu_ctrl.sv =====
`default_nettype none
module lfu_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output lfu_pkg::lfu_cmd_t      cmd,
	input  wire lfu_pkg::lfu_sts_t sts
);
	import lfu_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_COMMIT = 4'b0100,
		ST_OUT    = 4'b1000
	} state_t;

	state_t state_q;
	logic   in_acc;

	// The input is taken while idle, or while the last result is being taken.
	assign in_ready  = (state_q == ST_IDLE) || ((state_q == ST_OUT) && out_ready);
	assign out_valid = (state_q == ST_OUT);
	assign in_acc    = in_valid && in_ready;

	always_comb begin
		cmd.load   = in_acc;
		cmd.scan   = (state_q == ST_SCAN);
		cmd.commit = (state_q == ST_COMMIT);
	end

	// Sequence: scan the entries one by one, then commit, then hold the result until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (sts.scan_last) state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (in_acc) state_q <= ST_SCAN;
					else if (out_ready) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/lfu_dpath.sv =====
`default_nettype none
module lfu_dpath #(
	parameter int ENTRIES = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     capacity_limit_we,
	input  wire logic [lfu_pkg::LIM_W-1:0] capacity_limit,
	input  wire logic                     action,
	input  wire logic [lfu_pkg::KEY_W-1:0] lookup_key,
	input  wire logic [lfu_pkg::VAL_W-1:0] store_value,
	input  wire lfu_pkg::lfu_cmd_t         cmd,
	output lfu_pkg::lfu_sts_t              sts,
	output logic                          found,
	output logic [lfu_pkg::VAL_W-1:0]      read_value
);
	import lfu_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_W = $clog2(ENTRIES + 1);
	localparam int CAP_W = (OCC_W > LIM_W) ? OCC_W : LIM_W;

	// Entry store: valid bits in flip-flops, payload in registers read at one pointer.
	logic [ENTRIES-1:0]  valid_q;
	logic [KEY_W-1:0]    key_mem   [ENTRIES];
	logic [VAL_W-1:0]    val_mem   [ENTRIES];
	logic [CNT_W-1:0]    cnt_mem   [ENTRIES];
	logic [STAMP_W-1:0]  stamp_mem [ENTRIES];

	logic [LIM_W-1:0]    limit_q;
	logic [STAMP_W-1:0]  clock_q;
	logic [OCC_W-1:0]    occ_q;

	logic                act_q;
	logic [KEY_W-1:0]    key_q;
	logic [VAL_W-1:0]    val_q;
	logic [IDX_W-1:0]    ptr_q;

	logic                hit_q;
	logic [IDX_W-1:0]    hit_idx_q;
	logic [VAL_W-1:0]    hit_val_q;
	logic [CNT_W-1:0]    hit_cnt_q;
	logic                free_q;
	logic [IDX_W-1:0]    free_idx_q;
	logic                have_q;
	logic [IDX_W-1:0]    vic_idx_q;
	logic [CNT_W-1:0]    best_cnt_q;
	logic [STAMP_W-1:0]  best_age_q;

	logic [KEY_W-1:0]    rd_key;
	logic [CNT_W-1:0]    rd_cnt;
	logic [STAMP_W-1:0]  rd_age;
	logic                rd_valid;
	logic                better;

	logic [CAP_W-1:0]    cap;
	logic                full;
	logic                do_write;
	logic                do_insert;
	logic [IDX_W-1:0]    slot;

	assign sts.scan_last = (ptr_q == IDX_W'(ENTRIES - 1));

	assign rd_valid = valid_q[ptr_q];
	assign rd_key   = key_mem[ptr_q];
	assign rd_cnt   = cnt_mem[ptr_q];
	assign rd_age   = clock_q - stamp_mem[ptr_q];
	assign better   = !have_q || (rd_cnt < best_cnt_q) ||
	                  ((rd_cnt == best_cnt_q) && (rd_age > best_age_q));

	// Effective limit, clamped to the table size.
	always_comb begin
		if (CAP_W'(limit_q) > CAP_W'(ENTRIES)) cap = CAP_W'(ENTRIES);
		else cap = CAP_W'(limit_q);
	end
	assign full      = CAP_W'(occ_q) >= cap;
	assign do_write  = (act_q == ACT_PUT) && (cap != '0);
	assign do_insert = do_write && !hit_q && (full ? have_q : free_q);
	assign slot      = hit_q ? hit_idx_q : (full ? vic_idx_q : free_idx_q);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) limit_q <= LIMIT_RESET;
		else if (capacity_limit_we) limit_q <= capacity_limit;
	end

	// Scan control and per-item bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
			have_q  <= 1'b0;
			valid_q <= '0;
			clock_q <= '0;
			occ_q   <= '0;
		end else begin
			if (cmd.load) begin
				ptr_q  <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
				have_q <= 1'b0;
			end else if (cmd.scan) begin
				ptr_q <= ptr_q + 1'b1;
				if (rd_valid && rd_key == key_q && !hit_q) hit_q <= 1'b1;
				if (!rd_valid && !free_q) free_q <= 1'b1;
				if (rd_valid && better) have_q <= 1'b1;
			end else if (cmd.commit) begin
				if ((act_q == ACT_GET && hit_q) || (do_write && hit_q) || do_insert) begin
					clock_q <= clock_q + 1'b1;
				end
				if (do_insert) begin
					valid_q[slot] <= 1'b1;
					if (!full) occ_q <= occ_q + 1'b1;
				end
			end
		end
	end

	// Payload registers of the scan.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action;
			key_q <= lookup_key;
			val_q <= store_value;
		end else if (cmd.scan) begin
			if (rd_valid && rd_key == key_q && !hit_q) begin
				hit_idx_q <= ptr_q;
				hit_val_q <= val_mem[ptr_q];
				hit_cnt_q <= rd_cnt;
			end
			if (!rd_valid && !free_q) free_idx_q <= ptr_q;
			if (rd_valid && better) begin
				vic_idx_q  <= ptr_q;
				best_cnt_q <= rd_cnt;
				best_age_q <= rd_age;
			end
		end
	end

	// Entry updates and result word.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			found <= hit_q;
			if (act_q == ACT_GET) read_value <= hit_q ? hit_val_q : MISS_VALUE;
			else read_value <= '0;
			if (hit_q && (act_q == ACT_GET || do_write)) begin
				if (hit_cnt_q != COUNT_MAX) cnt_mem[hit_idx_q] <= hit_cnt_q + 1'b1;
				stamp_mem[hit_idx_q] <= clock_q;
				if (do_write) val_mem[hit_idx_q] <= val_q;
			end else if (do_insert) begin
				key_mem[slot]   <= key_q;
				val_mem[slot]   <= val_q;
				cnt_mem[slot]   <= CNT_W'(1);
				stamp_mem[slot] <= clock_q;
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/lfu_cache_table_core.sv =====
`default_nettype none
// LFU key/value table with least-recently-touched tie break. Each accepted word is
// a get or a put; one result word follows for each. For each item the sequencer
// walks every entry, one register-file read per cycle, for the key match, the first
// free slot and the eviction victim, then commits the update. The next word is
// accepted in the cycle its predecessor's result is taken. The table is empty after
// reset; capacity_limit resets to 16.
module lfu_cache_table_core #(
	parameter int ENTRIES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        capacity_limit_we,
	input  wire logic [4:0]  capacity_limit,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        action,
	input  wire logic [31:0] lookup_key,
	input  wire logic [31:0] store_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             found,
	output logic [31:0]      read_value
);
	import lfu_pkg::*;

	lfu_cmd_t cmd;
	lfu_sts_t sts;

	lfu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	lfu_dpath #(.ENTRIES(ENTRIES)) u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.capacity_limit_we (capacity_limit_we),
		.capacity_limit    (capacity_limit),
		.action            (action),
		.lookup_key        (lookup_key),
		.store_value       (store_value),
		.cmd               (cmd),
		.sts               (sts),
		.found             (found),
		.read_value        (read_value)
	);

`ifndef SYNTHESIS
	// A word is never accepted while a scan or commit is in progress.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan || cmd.commit) |-> !in_ready) else $error("accept while busy");
	// A result appears only right after a commit.
	a_out_after_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.commit)) else $error("result without commit");
	// A miss reports either the all-ones miss value or zero.
	a_miss_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found && read_value != 32'hFFFF_FFFF) |-> (read_value == 32'd0))
		else $error("bad miss value");
`endif
endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb;
	import lfu_pkg::*;

	localparam int N_ENT = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD = 300;

	typedef struct packed {
		logic        act;
		logic [31:0] key;
		logic [31:0] val;
	} word_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] data;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic lim_we = 1'b0;
	logic [4:0] lim_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic action = 1'b0;
	logic [31:0] lookup_key = '0;
	logic [31:0] store_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic found;
	logic [31:0] read_value;

	lfu_cache_table_core dut (
		.clk(clk), .arst_n(arst_n),
		.capacity_limit_we(lim_we), .capacity_limit(lim_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .lookup_key(lookup_key), .store_value(store_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.found(found), .read_value(read_value)
	);

	always #6 clk = ~clk;

	// Shadow copy of the table.
	logic [4:0]  m_limit;
	logic        m_vld [N_ENT];
	logic [31:0] m_key [N_ENT];
	logic [31:0] m_val [N_ENT];
	logic [15:0] m_cnt [N_ENT];
	logic [31:0] m_stamp [N_ENT];
	logic [31:0] m_clock;
	int          m_occ;

	word_t  pending_words[$];
	reply_t expected_replies[$];
	int     errors = 0;
	int     sent = 0;
	int     cycles = 0;
	bit     hold_now = 0;
	bit     sink_hold = 0;

	function automatic void table_clear();
		m_limit = LIMIT_RESET;
		for (int i = 0; i < N_ENT; i++) begin
			m_vld[i] = 1'b0; m_key[i] = '0; m_val[i] = '0; m_cnt[i] = '0; m_stamp[i] = '0;
		end
		m_clock = '0;
		m_occ = 0;
	endfunction

	function automatic void mark_touched(int i, bit raise);
		if (raise && m_cnt[i] != COUNT_MAX)
			m_cnt[i] = m_cnt[i] + 16'd1;
		m_stamp[i] = m_clock;
		m_clock = m_clock + 32'd1;
	endfunction

	// Predict the reply to one word and update the shadow table.
	function automatic reply_t table_access(word_t w);
		reply_t r;
		int cap, slot, hit_i;
		bit hit, have;
		logic [31:0] age, best_age;
		logic [15:0] best_cnt;
		cap = (m_limit > N_ENT) ? N_ENT : m_limit;
		hit = 1'b0; hit_i = 0;
		for (int i = N_ENT - 1; i >= 0; i--)
			if (m_vld[i] && m_key[i] == w.key) begin
				hit = 1'b1; hit_i = i;
			end
		r.hit = hit;
		r.data = '0;
		if (w.act == ACT_GET) begin
			if (hit) begin
				r.data = m_val[hit_i];
				mark_touched(hit_i, 1'b1);
			end else
				r.data = MISS_VALUE;
			return r;
		end
		if (cap == 0)
			return r;
		if (hit) begin
			m_val[hit_i] = w.val;
			mark_touched(hit_i, 1'b1);
			return r;
		end
		have = 1'b0; slot = 0; best_cnt = '0; best_age = '0;
		if (m_occ >= cap) begin
			for (int i = 0; i < N_ENT; i++) begin
				if (!m_vld[i])
					continue;
				age = m_clock - m_stamp[i];
				if (!have || m_cnt[i] < best_cnt || (m_cnt[i] == best_cnt && age > best_age)) begin
					have = 1'b1; slot = i; best_cnt = m_cnt[i]; best_age = age;
				end
			end
		end else begin
			for (int i = N_ENT - 1; i >= 0; i--)
				if (!m_vld[i]) begin
					have = 1'b1; slot = i;
				end
			if (have)
				m_occ++;
		end
		if (have) begin
			m_vld[slot] = 1'b1; m_key[slot] = w.key; m_val[slot] = w.val; m_cnt[slot] = 16'd1;
			mark_touched(slot, 1'b0);
		end
		return r;
	endfunction

	// Driver: bursts of words with random gaps.
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk) begin
		word_t w;
		cycles <= cycles + 1;
		if (!(in_valid && !in_ready)) begin
			if (in_valid && in_ready) begin
				expected_replies.push_back(table_access('{action, lookup_key, store_value}));
				sent <= sent + 1;
			end
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_words.size() > 0 && !hold_now) begin
				w = pending_words.pop_front();
				in_valid <= 1'b1;
				action <= w.act;
				lookup_key <= w.key;
				store_value <= w.val;
				if (burst_left > 0)
					burst_left <= burst_left - 1;
				else begin
					burst_left <= $urandom_range(0, 12);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
				end
			end else
				in_valid <= 1'b0;
		end
	end

	// Receiver stall pattern, with one long hold-off counted here once requested.
	int stall_phase = 0;
	int hold_left = 0;
	bit hold_taken = 0;
	always @(posedge clk) begin
		stall_phase <= stall_phase + 1;
		if (sink_hold && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left <= LONG_HOLD;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (stall_phase[9])
			out_ready <= 1'b1;
		else
			out_ready <= (stall_phase % 7 < 3) ? 1'b1 : ($urandom_range(0, 2) == 0);
	end

	// Monitor: compare every reply word with the oldest prediction.
	always @(posedge clk) begin
		reply_t e;
		if (out_valid && out_ready) begin
			if (expected_replies.size() == 0) begin
				$display("%0t: unexpected reply found=%0b value=%h", $time, found, read_value);
				errors++;
			end else begin
				e = expected_replies.pop_front();
				if (found !== e.hit) begin
					$display("%0t: found expected %0b actual %0b", $time, e.hit, found);
					errors++;
				end
				if (read_value !== e.data) begin
					$display("%0t: read_value expected %h actual %h", $time, e.data, read_value);
					errors++;
				end
			end
		end
	end

	always @(posedge clk)
		if (cycles > CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end

	task automatic push_word(logic a, logic [31:0] k, logic [31:0] v);
		pending_words.push_back('{a, k, v});
	endtask

	// Wait until all words are taken and answered.
	task automatic drain();
		wait (pending_words.size() == 0);
		@(posedge clk);
		while (in_valid || expected_replies.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_limit(logic [4:0] v);
		lim_we <= 1'b1;
		lim_data <= v;
		@(posedge clk);
		lim_we <= 1'b0;
		m_limit = v;
	endtask

	// Random words from a small key pool so hits and evictions are common.
	task automatic random_words(int n, int pool);
		logic [31:0] k;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				k = $urandom;
			else
				k = 32'h8000_0000 ^ $urandom_range(0, pool);
			push_word(1'($urandom_range(0, 1)), k, $urandom);
		end
	endtask

	initial begin
		table_clear();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, miss, hit, overwrite.
		push_word(ACT_GET, 32'h0, 32'h0);
		push_word(ACT_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		push_word(ACT_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		push_word(ACT_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_word(ACT_GET, 32'h7FFF_FFFF, 32'h1234);
		push_word(ACT_PUT, 32'h8000_0000, 32'h0);
		push_word(ACT_GET, 32'h8000_0000, 32'hFFFF_FFFF);
		push_word(ACT_GET, 32'hFFFF_FFFF, 32'h0);
		for (int i = 0; i < 10; i++)
			push_word(ACT_PUT, 32'(i), ~32'(i));
		push_word(ACT_GET, 32'h5, 32'h0);
		drain();

		// A full table: eviction on lowest count.
		set_limit(5'd31);
		for (int i = 20; i < 24; i++)
			push_word(ACT_PUT, 32'(i), 32'(i));
		push_word(ACT_GET, 32'h0, 32'h0);
		drain();

		set_limit(5'd0);
		push_word(ACT_PUT, 32'h77, 32'h1);
		push_word(ACT_PUT, 32'h5, 32'h1);
		push_word(ACT_GET, 32'h5, 32'h0);
		drain();

		// Lowered below occupancy, then a single-entry table.
		set_limit(5'd3);
		random_words(150, 8);
		drain();
		set_limit(5'd1);
		random_words(100, 4);
		drain();

		// Long receiver hold-off while the sender keeps offering.
		set_limit(5'd16);
		random_words(40, 24);
		sink_hold = 1;
		drain();

		// Pause the sender while new words are queued, then carry on.
		hold_now = 1;
		random_words(20, 24);
		repeat (50) @(posedge clk);
		hold_now = 0;
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			set_limit(5'($urandom_range(0, 31)));
			random_words(100, 4 + ph * 6);
			drain();
		end
		set_limit(5'd16);
		random_words(150, 30);
		drain();

		if (errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end
endmodule
`default_nettype wire
